/* rtl/rws_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regression slope package
// Fixed field widths and result status codes shared by the slope core and
// its checker.
// ----------------------------------------------------------------------------
package rws_pkg;

	localparam int SAMPLE_PORT_W = 32;
	localparam int WL_W          = 13;
	localparam int SLOPE_W       = 40;
	localparam int STATUS_W      = 2;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_SHORT   = 2'd1,
		STATUS_MISSING = 2'd2
	} status_t;

endpackage

/* rtl/rws_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned division, one quotient bit per cycle; quotient and remainder hold
// after done until the next start.
// ----------------------------------------------------------------------------
module rws_div #(
	parameter int NUM_W = 60,
	parameter int DEN_W = 39
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot,
	output logic [DEN_W-1:0] rem
);

	localparam int ITER_W = $clog2(NUM_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [ITER_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W-1:0]  dvs_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ITER_W'(1);
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			dvs_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

/* rtl/windowed_regression_slope_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed regression slope core
// Least-squares slope of a sample series against its index, over a leading
// window of the series.
// ----------------------------------------------------------------------------
// Each sample item is taken while the input is not stalled; one that lies in
// the window and is present is folded into the running sums with a single
// multiply-accumulate. The item that closes a series with enough samples and
// none missing holds the input stalled through S_CLOSE; the S_SQ, S_DEN and
// S_TPROD steps of one shared multiplier, which with S_TDIFF form the
// numerator and denominator; a restoring divider that produces one quotient
// bit per cycle; and S_ROUND and S_FINISH. A closing item that ends in a
// failed status holds the input stalled through S_CLOSE and S_FINISH. Either
// stall grows while an earlier result item still waits. A finished result
// waits in the output register while the next series starts. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module windowed_regression_slope_core #(
	parameter int MAX_WINDOW   = 4096,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [rws_pkg::WL_W-1:0]           cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [rws_pkg::SAMPLE_PORT_W-1:0]  sample_value,
	input  logic                               sample_present,
	input  logic                               last_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [rws_pkg::SLOPE_W-1:0]        slope_value,
	output logic [rws_pkg::STATUS_W-1:0]       result_status
);

	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int SY_W   = SAMPLE_WIDTH + CNT_W;
	localparam int SXY_W  = SAMPLE_WIDTH + 2 * CNT_W;
	localparam int XY_W   = CNT_W + 1 + SAMPLE_WIDTH;
	localparam int MA_W   = CNT_W + 1;
	localparam int MB_W   = (SY_W > 2 * CNT_W + 1) ? SY_W : 2 * CNT_W + 1;
	localparam int MP_W   = MA_W + MB_W;
	localparam int DEN_W  = 3 * CNT_W;
	localparam int NUM_W  = SAMPLE_WIDTH + 2 * CNT_W + 2;
	localparam int D_W    = (SXY_W + 2 > MP_W + 1) ? SXY_W + 2 : MP_W + 1;
	localparam int SL_W   = rws_pkg::SLOPE_W;
	localparam int QX_W   = (NUM_W + 1 > SL_W + 1) ? NUM_W + 1 : SL_W + 1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLOSE,
		S_SQ,
		S_DEN,
		S_TPROD,
		S_TDIFF,
		S_DIVIDE,
		S_ROUND,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic [rws_pkg::WL_W-1:0]  window_limit_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [SY_W-1:0]    sy_q;
	logic signed [SXY_W-1:0]   sxy_q;
	logic                      miss_q;
	logic                      out_valid_q;
	logic                      div_start_q;
	rws_pkg::status_t          status_res_q;
	rws_pkg::status_t          status_q;
	logic [SL_W-1:0]           slope_q;
	logic [SL_W-1:0]           slope_res_q;
	logic signed [MP_W-1:0]    prod_q;
	logic [DEN_W-1:0]          den_q;
	logic [NUM_W-1:0]          num_q;
	logic                      neg_q;

	logic [CNT_W-1:0]          win;
	logic                      in_window;
	logic signed [SAMPLE_WIDTH-1:0] y;
	logic signed [XY_W-1:0]    xy;
	logic signed [MA_W-1:0]    mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [MP_W-1:0]    mul_p;
	logic signed [D_W-1:0]     t_d;
	logic [D_W-1:0]            mag;
	logic [NUM_W-1:0]          mag_n;
	logic [NUM_W-1:0]          num_next;
	logic                      div_done;
	logic [NUM_W-1:0]          div_quot;
	logic [DEN_W-1:0]          div_rem;
	logic [DEN_W:0]            rem2;
	logic                      round_up;
	logic [QX_W-1:0]           q_up;
	logic [QX_W-1:0]           q_lim;
	logic [QX_W-1:0]           q_sat;
	logic [SL_W-1:0]           q_mag;
	logic                      out_free;

	always_comb begin
		if (window_limit_q == '0 || 32'(window_limit_q) > 32'(MAX_WINDOW)) begin
			win = CNT_W'(MAX_WINDOW);
		end else begin
			win = CNT_W'(window_limit_q);
		end
	end

	assign in_window = count_q < win;
	assign y         = sample_value[SAMPLE_WIDTH-1:0];
	assign xy        = $signed({1'b0, count_q}) * y;
	assign in_stall  = state_q != S_IDLE;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		case (state_q)
			S_SQ: begin
				mul_a = MA_W'(count_q);
				mul_b = MB_W'(count_q);
			end
			S_DEN: begin
				mul_a = MA_W'(count_q);
				mul_b = MB_W'(prod_q - MP_W'(1));
			end
			S_TPROD: begin
				mul_a = MA_W'(count_q - CNT_W'(1));
				mul_b = MB_W'(sy_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p    = mul_a * mul_b;
	assign t_d      = (D_W'(sxy_q) <<< 1) - D_W'(prod_q);
	assign mag      = t_d[D_W-1] ? D_W'(-t_d) : D_W'(t_d);
	assign mag_n    = NUM_W'(mag);
	assign num_next = (mag_n << 2) + (mag_n << 1);

	assign rem2     = {div_rem, 1'b0};
	assign round_up = rem2 >= {1'b0, den_q};
	assign q_up     = QX_W'(div_quot) + QX_W'(round_up);
	assign q_lim    = neg_q ? (QX_W'(1) << (SL_W - 1))
	                        : (QX_W'(1) << (SL_W - 1)) - QX_W'(1);
	assign q_sat    = (q_up > q_lim) ? q_lim : q_up;
	assign q_mag    = q_sat[SL_W-1:0];

	rws_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			window_limit_q <= '0;
			count_q        <= '0;
			sy_q           <= '0;
			sxy_q          <= '0;
			miss_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			div_start_q    <= 1'b0;
			status_res_q   <= rws_pkg::STATUS_OK;
		end else begin
			div_start_q <= (state_q == S_TDIFF);
			if (cfg_wr_en) begin
				window_limit_q <= cfg_wr_data;
			end
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_window) begin
							if (sample_present) begin
								sy_q  <= sy_q + SY_W'(y);
								sxy_q <= sxy_q + SXY_W'(xy);
							end else begin
								miss_q <= 1'b1;
							end
							count_q <= count_q + CNT_W'(1);
						end
						if (last_sample) begin
							state_q <= S_CLOSE;
						end
					end
				end
				S_CLOSE: begin
					if (count_q < CNT_W'(2)) begin
						status_res_q <= rws_pkg::STATUS_SHORT;
						state_q      <= S_FINISH;
					end else if (miss_q) begin
						status_res_q <= rws_pkg::STATUS_MISSING;
						state_q      <= S_FINISH;
					end else begin
						status_res_q <= rws_pkg::STATUS_OK;
						state_q      <= S_SQ;
					end
				end
				S_SQ:    state_q <= S_DEN;
				S_DEN:   state_q <= S_TPROD;
				S_TPROD: state_q <= S_TDIFF;
				S_TDIFF: state_q <= S_DIVIDE;
				S_DIVIDE: begin
					if (div_done) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: state_q <= S_FINISH;
				S_FINISH: begin
					if (out_free) begin
						count_q     <= '0;
						sy_q        <= '0;
						sxy_q       <= '0;
						miss_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_SQ:    prod_q <= mul_p;
			S_DEN:   den_q  <= DEN_W'(mul_p);
			S_TPROD: prod_q <= mul_p;
			S_TDIFF: begin
				num_q <= num_next;
				neg_q <= t_d[D_W-1];
			end
			S_ROUND: slope_res_q <= neg_q ? SL_W'(-q_mag) : q_mag;
			S_FINISH: begin
				if (out_free) begin
					slope_q  <= (status_res_q == rws_pkg::STATUS_OK) ? slope_res_q : '0;
					status_q <= status_res_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign slope_value   = slope_q;
	assign result_status = status_q;

endmodule

/* rtl/rws_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Regression slope checker
// Port-level checks on the slope core, bound to its top level.
// ----------------------------------------------------------------------------
module rws_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          last_sample,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [rws_pkg::SLOPE_W-1:0]   slope_value,
	input logic [rws_pkg::STATUS_W-1:0]  result_status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slope_value) && $stable(result_status))
		else $error("stalled result item changed");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_status != rws_pkg::STATUS_OK |-> slope_value == '0)
		else $error("failed result item carries a nonzero slope");

	a_mid_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_sample |=> !in_stall)
		else $error("input stalled after a mid-series item");

	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_sample |=> in_stall && !$rose(out_valid))
		else $error("closing item did not hold the input or gave an early result");

endmodule

bind windowed_regression_slope_core rws_checker u_rws_checker (.*);
